// ===== sv/diff_drive_odometry_unit_macros.svh =====
// assertion macros for the odometry unit
// no dependencies; expects clk and rst_n in the including scope
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// implication checked every clock edge outside reset
`define DDO_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddo assertion failed");

// condition that must never hold outside reset
`define DDO_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ddo assertion failed");

`endif

// ===== sv/ddo_pkg.sv =====
// shared types, constants and helpers for the odometry unit
// no dependencies
package ddo_pkg;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] left_wheel_rate;
        logic signed [15:0] right_wheel_rate;
        logic [15:0]        tick_interval;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading_angle;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] linear_speed;
        logic signed [31:0] turn_rate;
    } out_item_t;

    localparam logic OP_WHEEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic REG_WHEEL_RADIUS = 1'b0;
    localparam logic REG_WHEEL_TRACK  = 1'b1;

    localparam logic [15:0] RADIUS_RESET = 16'd6554;
    localparam logic [15:0] TRACK_RESET  = 16'd4915;

    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam int ATAN_DEPTH = 24;
    localparam logic [31:0] ATAN_BAM [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // multiplier operations
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_LIN  = 4'd1;
    localparam logic [3:0] MUL_NUM  = 4'd2;
    localparam logic [3:0] MUL_VDT  = 4'd3;
    localparam logic [3:0] MUL_ANG  = 4'd4;
    localparam logic [3:0] MUL_LO   = 4'd5;
    localparam logic [3:0] MUL_HI   = 4'd6;
    localparam logic [3:0] MUL_X    = 4'd7;
    localparam logic [3:0] MUL_Y    = 4'd8;

    localparam logic CORDIC_SEL_HEADING = 1'b0;
    localparam logic CORDIC_SEL_HALF    = 1'b1;

    typedef struct packed {
        logic       capture;
        logic [3:0] mul_op;
        logic       cordic_start;
        logic       cordic_sel;
        logic       div_start;
        logic       turn_direct;
        logic       turn_div;
        logic       load_out;
    } ddo_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic track_zero;
        logic div_busy;
        logic cordic_busy;
        logic out_full;
    } ddo_status_t;

    // rounded arithmetic shift right, halves away from zero
    function automatic logic signed [67:0] rshr68(input logic signed [67:0] v,
                                                  input int unsigned s);
        logic [67:0] mag;
        logic [67:0] r;
        mag = v[67] ? 68'(-v) : 68'(v);
        r = (mag + (68'd1 << (s - 1))) >> s;
        return v[67] ? $signed(68'(-r)) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -40'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== sv/ddo_cordic.sv =====
// iterative rotation-mode cordic giving cos and sin of a binary angle in q1.30
// depends on ddo_pkg
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               busy,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] HALF    = 34'sd2147483648;

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               neg_reg, neg_next;

    logic signed [33:0] a_ext, dx, dy, at, xc, yc;

    always_comb
    begin
        a_ext = 34'(angle);
        dx = x_reg >>> cnt_reg;
        dy = y_reg >>> cnt_reg;
        at = $signed({2'b00, ATAN_BAM[5'(cnt_reg)]});
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        neg_next = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            x_next = CORDIC_GAIN_Q30;
            y_next = '0;
            if (a_ext > QUARTER)
            begin
                z_next = a_ext - HALF;
                neg_next = 1'b1;
            end
            else if (a_ext < -QUARTER)
            begin
                z_next = a_ext + HALF;
                neg_next = 1'b1;
            end
            else
            begin
                z_next = a_ext;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + at;
            end
            if (cnt_reg == LAST)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        neg_reg <= neg_next;
    end

    // clamp to +-1 and undo the half-turn fold
    always_comb
    begin
        if (x_reg > ONE_Q30)       xc = ONE_Q30;
        else if (x_reg < -ONE_Q30) xc = -ONE_Q30;
        else                       xc = x_reg;
        if (y_reg > ONE_Q30)       yc = ONE_Q30;
        else if (y_reg < -ONE_Q30) yc = -ONE_Q30;
        else                       yc = y_reg;
    end

    assign busy = busy_reg;
    assign cos_out = neg_reg ? 32'(-xc) : 32'(xc);
    assign sin_out = neg_reg ? 32'(-yc) : 32'(yc);

endmodule

// ===== sv/ddo_divider.sv =====
// restoring divider, one quotient bit per cycle
// depends on nothing
module ddo_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [37:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [37:0] quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [37:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[37]};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[36:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[36:0], 1'b0};
            end
            if (cnt_reg == 6'd37)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/ddo_datapath.sv =====
// odometry datapath: config, state, shared multiplier, cordic, divider, output register
// depends on ddo_pkg, ddo_cordic, ddo_divider
module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  in_item_t    in_data,
    input  ddo_cmd_t    cmd,
    output ddo_status_t status,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic [15:0]        radius_reg, track_reg;
    logic signed [16:0] lsum_reg, ldiff_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] lin_vel_reg, lin_vel_next, ang_vel_reg, ang_vel_next;
    logic signed [31:0] x_accum_reg, x_accum_next, y_accum_reg, y_accum_next;
    logic [31:0]        heading_reg, heading_next;
    logic signed [33:0] vdt_reg;
    logic [47:0]        pmag_reg;
    logic               pneg_reg, num_neg_reg, m_zero_reg;
    logic [55:0]        lo_reg;
    logic [36:0]        m_reg;
    logic signed [67:0] prod_reg;
    logic [3:0]         mul_op_q_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic signed [33:0] mul_a, mul_b;
    logic [67:0]        prod_mag;
    logic signed [67:0] prod_rnd11, prod_rnd16, prod_rnd30, qz_rnd, qw_rnd;
    logic [79:0]        bam_sum;
    logic [31:0]        bam_delta;
    logic signed [39:0] pos_sum;
    logic [37:0]        div_dividend;
    logic [37:0]        div_q;
    logic               div_busy, cordic_busy;
    logic signed [31:0] cordic_angle, cos_v, sin_v;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_LIN:
            begin
                mul_a = $signed({18'd0, radius_reg});
                mul_b = 34'(lsum_reg);
            end
            MUL_NUM:
            begin
                mul_a = $signed({18'd0, radius_reg});
                mul_b = 34'(ldiff_reg);
            end
            MUL_VDT:
            begin
                mul_a = 34'(lin_vel_reg);
                mul_b = $signed({18'd0, dt_reg});
            end
            MUL_ANG:
            begin
                mul_a = 34'(ang_vel_reg);
                mul_b = $signed({18'd0, dt_reg});
            end
            MUL_LO:
            begin
                mul_a = $signed({10'd0, pmag_reg[23:0]});
                mul_b = $signed({4'd0, INV_TWO_PI_Q32});
            end
            MUL_HI:
            begin
                mul_a = $signed({10'd0, pmag_reg[47:24]});
                mul_b = $signed({4'd0, INV_TWO_PI_Q32});
            end
            MUL_X:
            begin
                mul_a = vdt_reg;
                mul_b = 34'(cos_v);
            end
            MUL_Y:
            begin
                mul_a = vdt_reg;
                mul_b = 34'(sin_v);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // writeback of the registered product
    always_comb
    begin
        prod_mag = prod_reg[67] ? 68'(-prod_reg) : 68'(prod_reg);
        prod_rnd11 = rshr68(prod_reg, 11);
        prod_rnd16 = rshr68(prod_reg, 16);
        prod_rnd30 = rshr68(prod_reg, 30);
        bam_sum = {prod_reg[55:0], 24'd0} + {24'd0, lo_reg};
        bam_delta = bam_sum[63:32];
        pos_sum = (mul_op_q_reg == MUL_X) ? 40'(x_accum_reg) : 40'(y_accum_reg);
        pos_sum = pos_sum + prod_rnd30[39:0];
        div_dividend = {1'b0, m_reg} + {23'd0, track_reg[15:1]};

        lin_vel_next = lin_vel_reg;
        ang_vel_next = ang_vel_reg;
        x_accum_next = x_accum_reg;
        y_accum_next = y_accum_reg;
        heading_next = heading_reg;
        if (mul_op_q_reg == MUL_LIN)
            lin_vel_next = prod_rnd11[31:0];
        if (mul_op_q_reg == MUL_HI)
            heading_next = pneg_reg ? heading_reg - bam_delta : heading_reg + bam_delta;
        if (mul_op_q_reg == MUL_X)
            x_accum_next = sat40(pos_sum);
        if (mul_op_q_reg == MUL_Y)
            y_accum_next = sat40(pos_sum);
        if (cmd.turn_direct)
        begin
            if (m_zero_reg)
                ang_vel_next = '0;
            else
                ang_vel_next = num_neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        if (cmd.turn_div)
        begin
            if (num_neg_reg)
                ang_vel_next = (div_q > 38'h0080000000) ? 32'sh80000000 : 32'(-div_q);
            else
                ang_vel_next = (div_q > 38'h007FFFFFFF) ? 32'sh7FFFFFFF : div_q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            track_reg <= TRACK_RESET;
            lin_vel_reg <= '0;
            ang_vel_reg <= '0;
            x_accum_reg <= '0;
            y_accum_reg <= '0;
            heading_reg <= '0;
            mul_op_q_reg <= MUL_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WHEEL_RADIUS)
                radius_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_WHEEL_TRACK)
                track_reg <= cfg_wdata;
            lin_vel_reg <= lin_vel_next;
            ang_vel_reg <= ang_vel_next;
            x_accum_reg <= x_accum_next;
            y_accum_reg <= y_accum_next;
            heading_reg <= heading_next;
            mul_op_q_reg <= cmd.mul_op;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        qz_rnd = rshr68(68'(sin_v), 16);
        qw_rnd = rshr68(68'(cos_v), 16);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            lsum_reg <= 17'(in_data.left_wheel_rate) + 17'(in_data.right_wheel_rate);
            ldiff_reg <= 17'(in_data.right_wheel_rate) - 17'(in_data.left_wheel_rate);
            dt_reg <= in_data.tick_interval;
        end
        if (mul_op_q_reg == MUL_NUM)
        begin
            num_neg_reg <= prod_reg[67];
            m_reg <= {prod_mag[32:0], 4'd0};
            m_zero_reg <= (prod_mag == '0);
        end
        if (mul_op_q_reg == MUL_VDT)
            vdt_reg <= prod_rnd16[33:0];
        if (mul_op_q_reg == MUL_ANG)
        begin
            pneg_reg <= prod_reg[67];
            pmag_reg <= prod_mag[47:0];
        end
        if (mul_op_q_reg == MUL_LO)
            lo_reg <= prod_reg[55:0];
        if (cmd.load_out)
        begin
            out_reg.pos_x <= x_accum_reg;
            out_reg.pos_y <= y_accum_reg;
            out_reg.heading_angle <= heading_reg;
            out_reg.quat_z <= qz_rnd[15:0];
            out_reg.quat_w <= qw_rnd[15:0];
            out_reg.linear_speed <= lin_vel_reg;
            out_reg.turn_rate <= ang_vel_reg;
        end
    end

    assign cordic_angle = (cmd.cordic_sel == CORDIC_SEL_HALF) ?
                          $signed(heading_reg) >>> 1 : $signed(heading_reg);

    ddo_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cordic_start),
        .angle   (cordic_angle),
        .busy    (cordic_busy),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    ddo_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (track_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign status.m_zero = m_zero_reg;
    assign status.track_zero = (track_reg == '0);
    assign status.div_busy = div_busy;
    assign status.cordic_busy = cordic_busy;
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

// ===== sv/ddo_ctrl.sv =====
// odometry sequencer: steps the shared multiplier, cordic and divider
// depends on ddo_pkg
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_opcode,
    output logic        in_ready,
    input  ddo_status_t status,
    output ddo_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_W_LIN    = 5'd1;
    localparam logic [4:0] S_W_NUM    = 5'd2;
    localparam logic [4:0] S_W_WB     = 5'd3;
    localparam logic [4:0] S_W_DECIDE = 5'd4;
    localparam logic [4:0] S_W_DIV    = 5'd5;
    localparam logic [4:0] S_T_VDT    = 5'd6;
    localparam logic [4:0] S_T_ANG    = 5'd7;
    localparam logic [4:0] S_T_GAP    = 5'd8;
    localparam logic [4:0] S_T_LO     = 5'd9;
    localparam logic [4:0] S_T_HI     = 5'd10;
    localparam logic [4:0] S_T_HEAD   = 5'd11;
    localparam logic [4:0] S_T_CWAIT  = 5'd12;
    localparam logic [4:0] S_T_X      = 5'd13;
    localparam logic [4:0] S_T_Y      = 5'd14;
    localparam logic [4:0] S_T_Q      = 5'd15;
    localparam logic [4:0] S_T_QWAIT  = 5'd16;
    localparam logic [4:0] S_T_OUT    = 5'd17;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.mul_op = MUL_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = (in_opcode == OP_TICK) ? S_T_VDT : S_W_LIN;
            end
            S_W_LIN:
            begin
                cmd.mul_op = MUL_LIN;
                state_next = S_W_NUM;
            end
            S_W_NUM:
            begin
                cmd.mul_op = MUL_NUM;
                state_next = S_W_WB;
            end
            S_W_WB:
                state_next = S_W_DECIDE;
            S_W_DECIDE:
            begin
                if (status.m_zero || status.track_zero)
                begin
                    cmd.turn_direct = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_W_DIV;
                end
            end
            S_W_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.turn_div = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_T_VDT:
            begin
                cmd.mul_op = MUL_VDT;
                cmd.cordic_start = 1'b1;
                cmd.cordic_sel = CORDIC_SEL_HEADING;
                state_next = S_T_ANG;
            end
            S_T_ANG:
            begin
                cmd.mul_op = MUL_ANG;
                state_next = S_T_GAP;
            end
            S_T_GAP:
                state_next = S_T_LO;
            S_T_LO:
            begin
                cmd.mul_op = MUL_LO;
                state_next = S_T_HI;
            end
            S_T_HI:
            begin
                cmd.mul_op = MUL_HI;
                state_next = S_T_HEAD;
            end
            S_T_HEAD:
                state_next = S_T_CWAIT;
            S_T_CWAIT:
            begin
                if (!status.cordic_busy)
                    state_next = S_T_X;
            end
            S_T_X:
            begin
                cmd.mul_op = MUL_X;
                state_next = S_T_Y;
            end
            S_T_Y:
            begin
                cmd.mul_op = MUL_Y;
                state_next = S_T_Q;
            end
            S_T_Q:
            begin
                cmd.cordic_start = 1'b1;
                cmd.cordic_sel = CORDIC_SEL_HALF;
                state_next = S_T_QWAIT;
            end
            S_T_QWAIT:
            begin
                if (!status.cordic_busy)
                    state_next = S_T_OUT;
            end
            S_T_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/diff_drive_odometry_unit.sv =====
// top level of the differential-drive odometry unit
// depends on ddo_pkg, ddo_ctrl, ddo_datapath and the assertion macro header
//
// dead reckoning for a two-wheel robot. a wheel transaction (opcode 0) stores
// linear speed and turn rate and produces no result; its time from acceptance
// to the next ready is set by the bit-serial divider for the turn rate, which
// is skipped when the wheels agree or the radius or track is zero. a tick
// transaction (opcode 1) integrates x, y and heading and produces one result;
// its time is set by the two passes of the single iterative cordic. one
// transaction is worked at a time; a new one is accepted while the previous
// result still waits in the output register, and a tick only stalls at its
// end if that register is still occupied. all multiplies share one 34x34
// multiplier with a registered product.
module diff_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

`include "diff_drive_odometry_unit_macros.svh"

    ddo_cmd_t    cmd;
    ddo_status_t status;

    // sequencer
    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_data.opcode),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic, state and output register
    ddo_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // no new transaction while a shared unit is still working
    `DDO_ASSERT_NEVER(a_idle_cordic, in_ready && status.cordic_busy)
    `DDO_ASSERT_NEVER(a_idle_div, in_ready && status.div_busy)
    // a result never overwrites one that is still waiting
    `DDO_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !status.out_full)
    // an accepted transaction occupies the sequencer next cycle
    `DDO_ASSERT_IMPL(a_busy_after_accept, in_valid && in_ready, ##1 !in_ready)

endmodule
